// ===== hw/rtl/mbtcp_pkg.sv =====
// shared constants, job type and function codes for the modbus/tcp server engine
// no dependencies
package mbtcp_pkg;

    localparam int COIL_COUNT     = 256;
    localparam int REGISTER_COUNT = 256;
    localparam int MAX_PDU_BYTES  = 253;
    localparam int BEAT_BYTES     = 8;
    localparam int QUEUE_DEPTH    = 2;
    localparam int HDR_LEN        = 7;

    localparam int COIL_AW  = $clog2(COIL_COUNT);
    localparam int REG_AW   = $clog2(REGISTER_COUNT);
    localparam int ADDR_W   = (COIL_AW > REG_AW) ? COIL_AW : REG_AW;
    localparam int PDU_AW   = $clog2(MAX_PDU_BYTES);
    localparam int BEAT_W   = BEAT_BYTES * 8;
    localparam int BCNT_W   = $clog2(BEAT_BYTES + 1);

    localparam logic [7:0]  FC_READ_COILS  = 8'h01;
    localparam logic [7:0]  FC_READ_REGS   = 8'h03;
    localparam logic [7:0]  FC_WRITE_COIL  = 8'h05;
    localparam logic [7:0]  FC_WRITE_REG   = 8'h06;
    localparam logic [7:0]  FC_WRITE_MULTI = 8'h10;
    localparam logic [7:0]  EXC_FLAG       = 8'h80;
    localparam logic [7:0]  EXC_ILLEGAL_FUNC  = 8'h01;
    localparam logic [7:0]  EXC_ILLEGAL_ADDR  = 8'h02;
    localparam logic [7:0]  EXC_ILLEGAL_VALUE = 8'h03;
    localparam logic [15:0] COIL_ON         = 16'hFF00;
    localparam logic [15:0] COIL_OFF        = 16'h0000;
    localparam logic [15:0] MAX_READ_COILS  = 16'd2000;
    localparam logic [15:0] MAX_READ_REGS   = 16'd125;
    localparam logic [15:0] MAX_WRITE_REGS  = 16'd123;

    typedef enum logic [0:0] {
        REG_CRIT_LOW  = 1'b0,
        REG_CRIT_HIGH = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic        drop;
        logic [15:0] tid;
        logic [7:0]  unit;
        logic [7:0]  plen;
    } job_t;

endpackage

// ===== hw/rtl/modbus_tcp_server_engine_unit.sv =====
// Modbus/TCP server engine. Request bytes enter one per cycle on s_; the parser
// takes header bytes at full rate, save the last byte of a bad header while the
// job queue is full, and PDU bytes of a frame only while no earlier request is
// queued or being served, since the PDU buffer is a single memory. Serving a
// request loads the PDU head, writes each register of a write multiple registers,
// then emits the response bytes, fetching each register or coil byte read, all
// subject to backpressure on m_. Beats carry up to 8 bytes, big-endian; a bad
// header yields a single drop beat and the link stays silent until connection_start.
// Coil and register files read as zero after reset with no clearing pass.
// depends on mbtcp_pkg, mbtcp_ram, mbtcp_front, mbtcp_queue, mbtcp_back
module modbus_tcp_server_engine_unit import mbtcp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_stream_byte,
    input  logic        s_connection_start,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_beat_data,
    output logic [3:0]  m_beat_bytes,
    output logic        m_last_beat,
    output logic        m_drop,
    output logic        m_alert,
    output logic [7:0]  m_alert_address,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    logic [15:0]       crit_low_reg, crit_high_reg;
    logic              job_push, job_pop, q_not_empty, q_full, back_active, busy;
    job_t              job_in, job_head;
    logic              pdu_we;
    logic [PDU_AW-1:0] pdu_waddr, pdu_raddr;
    logic [7:0]        pdu_wdata, pdu_rdata;

    assign busy = q_not_empty || back_active;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crit_low_reg  <= 16'd100;
            crit_high_reg <= 16'd110;
        end else if (cfg_we) begin
            if (cfg_index == REG_CRIT_LOW) begin
                crit_low_reg <= cfg_wdata;
            end
            if (cfg_index == REG_CRIT_HIGH) begin
                crit_high_reg <= cfg_wdata;
            end
        end
    end

    mbtcp_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_stream_byte(s_stream_byte), .s_connection_start(s_connection_start),
        .busy(busy), .q_full(q_full),
        .job_push(job_push), .job_data(job_in),
        .pdu_we(pdu_we), .pdu_waddr(pdu_waddr), .pdu_wdata(pdu_wdata)
    );

    mbtcp_ram #(.WIDTH(8), .DEPTH(MAX_PDU_BYTES)) u_pdu_ram (
        .aclk(aclk), .we(pdu_we), .waddr(pdu_waddr), .wdata(pdu_wdata),
        .raddr(pdu_raddr), .rdata(pdu_rdata)
    );

    mbtcp_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .push(job_push), .push_data(job_in), .pop(job_pop),
        .head(job_head), .not_empty(q_not_empty), .full(q_full)
    );

    mbtcp_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .job_i(job_head), .job_valid(q_not_empty), .job_pop(job_pop),
        .pdu_raddr(pdu_raddr), .pdu_rdata(pdu_rdata),
        .crit_low(crit_low_reg), .crit_high(crit_high_reg),
        .active(back_active),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_beat_data(m_beat_data), .m_beat_bytes(m_beat_bytes),
        .m_last_beat(m_last_beat), .m_drop(m_drop),
        .m_alert(m_alert), .m_alert_address(m_alert_address)
    );

endmodule

// ===== hw/rtl/mbtcp_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
module mbtcp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/mbtcp_front.sv =====
// front end: mbap header parser, pdu buffer writer and job issue
// depends on mbtcp_pkg
module mbtcp_front import mbtcp_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_stream_byte,
    input  logic              s_connection_start,
    input  logic              busy,
    input  logic              q_full,
    output logic              job_push,
    output job_t              job_data,
    output logic              pdu_we,
    output logic [PDU_AW-1:0] pdu_waddr,
    output logic [7:0]        pdu_wdata
);

    logic [8:0]  pos_reg, pos_next, pos_eff, pdu_idx;
    logic [15:0] tid_reg, tid_next, tid_eff;
    logic [15:0] proto_reg, proto_next, proto_eff;
    logic [15:0] flen_reg, flen_next, flen_eff;
    logic [7:0]  unit_reg, unit_next, unit_eff;
    logic        dropped_reg, dropped_next, dropped_eff;
    logic [7:0]  plen;
    logic        hdr_end, hdr_bad, is_pdu, pdu_last, need_push, stall, acc;

    always_comb begin
        pos_eff     = s_connection_start ? '0 : pos_reg;
        tid_eff     = s_connection_start ? '0 : tid_reg;
        proto_eff   = s_connection_start ? '0 : proto_reg;
        flen_eff    = s_connection_start ? '0 : flen_reg;
        unit_eff    = s_connection_start ? '0 : unit_reg;
        dropped_eff = s_connection_start ? 1'b0 : dropped_reg;
        pdu_idx     = pos_eff - 9'(HDR_LEN);
        plen        = 8'(flen_eff - 16'd1);
        hdr_end     = (pos_eff == 9'(HDR_LEN - 1));
        hdr_bad     = (proto_eff != 16'd0) || (flen_eff < 16'd2)
                    || (flen_eff > 16'(MAX_PDU_BYTES + 1));
        is_pdu      = (pos_eff >= 9'(HDR_LEN));
        pdu_last    = is_pdu && ((pdu_idx + 9'd1) >= {1'b0, plen});
        need_push   = !dropped_eff && ((hdr_end && hdr_bad) || pdu_last);
        stall       = !dropped_eff && ((is_pdu && busy) || (need_push && q_full));
        s_ready     = !stall;
        acc         = s_valid && s_ready;

        job_push      = acc && need_push;
        job_data.drop = hdr_end;
        job_data.tid  = tid_eff;
        job_data.unit = hdr_end ? s_stream_byte : unit_eff;
        job_data.plen = plen;

        pdu_we    = acc && !dropped_eff && is_pdu;
        pdu_waddr = pdu_idx[PDU_AW-1:0];
        pdu_wdata = s_stream_byte;

        pos_next     = pos_reg;
        tid_next     = tid_reg;
        proto_next   = proto_reg;
        flen_next    = flen_reg;
        unit_next    = unit_reg;
        dropped_next = dropped_reg;
        if (acc) begin
            pos_next     = pos_eff;
            tid_next     = tid_eff;
            proto_next   = proto_eff;
            flen_next    = flen_eff;
            unit_next    = unit_eff;
            dropped_next = dropped_eff;
            if (!dropped_eff) begin
                pos_next = pos_eff + 9'd1;
                if (pos_eff < 9'd2) begin
                    tid_next = {tid_eff[7:0], s_stream_byte};
                end else if (pos_eff < 9'd4) begin
                    proto_next = {proto_eff[7:0], s_stream_byte};
                end else if (pos_eff < 9'd6) begin
                    flen_next = {flen_eff[7:0], s_stream_byte};
                end else if (hdr_end) begin
                    unit_next = s_stream_byte;
                    if (hdr_bad) begin
                        dropped_next = 1'b1;
                        pos_next     = '0;
                    end
                end else if (pdu_last) begin
                    pos_next = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            tid_reg     <= '0;
            proto_reg   <= '0;
            flen_reg    <= '0;
            unit_reg    <= '0;
            dropped_reg <= 1'b0;
        end else begin
            pos_reg     <= pos_next;
            tid_reg     <= tid_next;
            proto_reg   <= proto_next;
            flen_reg    <= flen_next;
            unit_reg    <= unit_next;
            dropped_reg <= dropped_next;
        end
    end

endmodule

// ===== hw/rtl/mbtcp_queue.sv =====
// short job queue between the parser and the request executor
// depends on mbtcp_pkg
module mbtcp_queue import mbtcp_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_data,
    input  logic pop,
    output job_t head,
    output logic not_empty,
    output logic full
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    job_t          slot_reg [QUEUE_DEPTH];
    logic [PW-1:0] wptr_reg, rptr_reg;
    logic [CW-1:0] cnt_reg;

    assign head      = slot_reg[rptr_reg];
    assign not_empty = (cnt_reg != '0);
    assign full      = (cnt_reg == CW'(QUEUE_DEPTH));

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            if (push) begin
                wptr_reg <= (wptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (pop) begin
                rptr_reg <= (rptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + CW'(push) - CW'(pop);
        end
    end

endmodule

// ===== hw/rtl/mbtcp_back.sv =====
// back end: serves one request on the coil and register files and packs response beats
// depends on mbtcp_pkg and mbtcp_ram
module mbtcp_back import mbtcp_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  job_t              job_i,
    input  logic              job_valid,
    output logic              job_pop,
    output logic [PDU_AW-1:0] pdu_raddr,
    input  logic [7:0]        pdu_rdata,
    input  logic [15:0]       crit_low,
    input  logic [15:0]       crit_high,
    output logic              active,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [63:0]       m_beat_data,
    output logic [3:0]        m_beat_bytes,
    output logic              m_last_beat,
    output logic              m_drop,
    output logic              m_alert,
    output logic [7:0]        m_alert_address
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_LOAD  = 7'b0000010,
        ST_CHECK = 7'b0000100,
        ST_WMUL  = 7'b0001000,
        ST_EMIT  = 7'b0010000,
        ST_FETCH = 7'b0100000,
        ST_DROP  = 7'b1000000
    } state_t;

    typedef enum logic [1:0] {
        K_EXC, K_COILS, K_REGS, K_ECHO
    } kind_t;

    state_t state_reg, state_next;
    kind_t  kind_reg, kind_next;
    job_t   job_reg, job_next;
    logic [7:0]  fc_reg, fc_next, bc_reg, bc_next, exc_reg, exc_next;
    logic [15:0] addr_reg, addr_next, qty_reg, qty_next;
    logic [7:0]  rlen_reg, rlen_next, idx_reg, idx_next;
    logic [3:0]  phase_reg, phase_next;
    logic [8:0]  n_reg, n_next;
    logic [ADDR_W-1:0] ptr_reg, ptr_next;
    logic [15:0] rem_reg, rem_next, word_reg, word_next;
    logic        have_reg, have_next, issued_reg, issued_next;
    logic        alert_reg, alert_next;
    logic [7:0]  aaddr_reg, aaddr_next;
    logic [BEAT_W-1:0] beat_reg, beat_next, beat_new;
    logic [BCNT_W-1:0] bcnt_reg, bcnt_next;

    logic              m_valid_reg, m_valid_next;
    logic [63:0]       m_data_reg, m_data_next;
    logic [3:0]        m_bytes_reg, m_bytes_next;
    logic              m_last_reg, m_last_next, m_drop_reg, m_drop_next;
    logic              m_alert_reg, m_alert_next;
    logic [7:0]        m_aaddr_reg, m_aaddr_next;

    logic [COIL_COUNT-1:0]     coil_vld_reg;
    logic [REGISTER_COUNT-1:0] rvld_reg;
    logic                      coil_vq_reg, rvq_reg;
    logic                      coil_we, coil_wdata, coil_q, coil_bit;
    logic [COIL_AW-1:0]        coil_waddr, coil_raddr;
    logic                      reg_we;
    logic [REG_AW-1:0]         reg_waddr, reg_raddr;
    logic [15:0]               reg_wdata, reg_q, reg_word;

    logic        out_free, out_push, is_last, complete, need_fetch, is_read;
    logic [16:0] span, file_sz;
    logic [15:0] read_lim, nb16, a_plus_i;
    logic [8:0]  total, p, rl1;
    logic [7:0]  byte_v;

    mbtcp_ram #(.WIDTH(1), .DEPTH(COIL_COUNT)) u_coil_ram (
        .aclk(aclk), .we(coil_we), .waddr(coil_waddr), .wdata(coil_wdata),
        .raddr(coil_raddr), .rdata(coil_q)
    );

    mbtcp_ram #(.WIDTH(16), .DEPTH(REGISTER_COUNT)) u_reg_ram (
        .aclk(aclk), .we(reg_we), .waddr(reg_waddr), .wdata(reg_wdata),
        .raddr(reg_raddr), .rdata(reg_q)
    );

    function automatic logic in_crit(input logic [15:0] a, input logic [15:0] lo,
                                     input logic [15:0] hi);
        return (a >= lo) && (a <= hi);
    endfunction

    assign coil_bit  = coil_vq_reg & coil_q;
    assign reg_word  = rvq_reg ? reg_q : 16'd0;
    assign coil_raddr = ptr_reg[COIL_AW-1:0];
    assign reg_raddr  = ptr_reg[REG_AW-1:0];
    assign out_free   = !m_valid_reg || m_ready;
    assign active     = (state_reg != ST_IDLE);

    assign m_valid         = m_valid_reg;
    assign m_beat_data     = m_data_reg;
    assign m_beat_bytes    = m_bytes_reg;
    assign m_last_beat     = m_last_reg;
    assign m_drop          = m_drop_reg;
    assign m_alert         = m_alert_reg;
    assign m_alert_address = m_aaddr_reg;

    always_comb begin
        span     = {1'b0, addr_reg} + {1'b0, qty_reg};
        is_read  = (fc_reg == FC_READ_COILS) || (fc_reg == FC_READ_REGS);
        read_lim = (fc_reg == FC_READ_COILS) ? MAX_READ_COILS : MAX_READ_REGS;
        file_sz  = (fc_reg == FC_READ_COILS) ? 17'(COIL_COUNT) : 17'(REGISTER_COUNT);
        nb16     = (qty_reg + 16'd7) >> 3;
        a_plus_i = addr_reg + {8'd0, idx_reg};
        total    = 9'(HDR_LEN) + {1'b0, rlen_reg};
        rl1      = {1'b0, rlen_reg} + 9'd1;
        p        = n_reg - 9'(HDR_LEN);
        is_last  = (n_reg == total - 9'd1);
        complete = (bcnt_reg == BCNT_W'(BEAT_BYTES - 1)) || is_last;
        need_fetch = ((kind_reg == K_COILS) || (kind_reg == K_REGS))
                   && (n_reg >= 9'(HDR_LEN)) && (p >= 9'd2) && !have_reg;

        byte_v = 8'd0;
        if (n_reg < 9'(HDR_LEN)) begin
            case (n_reg[2:0])
                3'd0:    byte_v = job_reg.tid[15:8];
                3'd1:    byte_v = job_reg.tid[7:0];
                3'd4:    byte_v = 8'(rl1 >> 8);
                3'd5:    byte_v = rl1[7:0];
                3'd6:    byte_v = job_reg.unit;
                default: byte_v = 8'd0;
            endcase
        end else if (p == 9'd0) begin
            byte_v = (kind_reg == K_EXC) ? (fc_reg | EXC_FLAG) : fc_reg;
        end else if (p == 9'd1) begin
            case (kind_reg)
                K_EXC:   byte_v = exc_reg;
                K_COILS: byte_v = nb16[7:0];
                K_REGS:  byte_v = 8'(qty_reg << 1);
                default: byte_v = addr_reg[15:8];
            endcase
        end else begin
            case (kind_reg)
                K_COILS: byte_v = word_reg[7:0];
                K_REGS:  byte_v = p[0] ? word_reg[7:0] : word_reg[15:8];
                K_ECHO: begin
                    if (p == 9'd2) begin
                        byte_v = addr_reg[7:0];
                    end else if (p == 9'd3) begin
                        byte_v = qty_reg[15:8];
                    end else begin
                        byte_v = qty_reg[7:0];
                    end
                end
                default: byte_v = 8'd0;
            endcase
        end
        beat_new = beat_reg | ({byte_v, {(BEAT_W - 8){1'b0}}} >> (8 * bcnt_reg));
    end

    always_comb begin
        state_next  = state_reg;
        kind_next   = kind_reg;
        job_next    = job_reg;
        fc_next     = fc_reg;
        bc_next     = bc_reg;
        exc_next    = exc_reg;
        addr_next   = addr_reg;
        qty_next    = qty_reg;
        rlen_next   = rlen_reg;
        idx_next    = idx_reg;
        phase_next  = phase_reg;
        n_next      = n_reg;
        ptr_next    = ptr_reg;
        rem_next    = rem_reg;
        word_next   = word_reg;
        have_next   = have_reg;
        issued_next = issued_reg;
        alert_next  = alert_reg;
        aaddr_next  = aaddr_reg;
        beat_next   = beat_reg;
        bcnt_next   = bcnt_reg;
        job_pop     = 1'b0;
        pdu_raddr   = idx_reg[PDU_AW-1:0];
        coil_we     = 1'b0;
        coil_waddr  = addr_reg[COIL_AW-1:0];
        coil_wdata  = (qty_reg == COIL_ON);
        reg_we      = 1'b0;
        reg_waddr   = addr_reg[REG_AW-1:0];
        reg_wdata   = qty_reg;
        out_push     = 1'b0;
        m_data_next  = m_data_reg;
        m_bytes_next = m_bytes_reg;
        m_last_next  = m_last_reg;
        m_drop_next  = m_drop_reg;
        m_alert_next = m_alert_reg;
        m_aaddr_next = m_aaddr_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (job_valid) begin
                    job_pop    = 1'b1;
                    job_next   = job_i;
                    idx_next   = '0;
                    state_next = job_i.drop ? ST_DROP : ST_LOAD;
                end
            end
            ST_LOAD: begin
                case (idx_reg[2:0])
                    3'd1:    fc_next = pdu_rdata;
                    3'd2:    addr_next[15:8] = pdu_rdata;
                    3'd3:    addr_next[7:0] = pdu_rdata;
                    3'd4:    qty_next[15:8] = pdu_rdata;
                    3'd5:    qty_next[7:0] = pdu_rdata;
                    3'd6:    bc_next = pdu_rdata;
                    default: fc_next = fc_reg;
                endcase
                idx_next = idx_reg + 8'd1;
                if (idx_reg == 8'd6) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                kind_next  = K_EXC;
                exc_next   = EXC_ILLEGAL_VALUE;
                rlen_next  = 8'd2;
                alert_next = 1'b0;
                aaddr_next = 8'd0;
                idx_next   = '0;
                phase_next = '0;
                n_next     = '0;
                have_next  = 1'b0;
                ptr_next   = addr_reg[ADDR_W-1:0];
                rem_next   = qty_reg;
                state_next = ST_EMIT;
                unique case (fc_reg) inside
                    FC_READ_COILS, FC_READ_REGS: begin
                        if (job_reg.plen == 8'd5 && qty_reg != 16'd0 && qty_reg <= read_lim) begin
                            if (span > file_sz) begin
                                exc_next = EXC_ILLEGAL_ADDR;
                            end else if (fc_reg == FC_READ_COILS) begin
                                kind_next = K_COILS;
                                rlen_next = 8'(nb16 + 16'd2);
                            end else begin
                                kind_next = K_REGS;
                                rlen_next = 8'((qty_reg << 1) + 16'd2);
                            end
                        end
                    end
                    FC_WRITE_COIL: begin
                        if (job_reg.plen == 8'd5
                            && (qty_reg == COIL_OFF || qty_reg == COIL_ON)) begin
                            if (addr_reg >= 16'(COIL_COUNT)) begin
                                exc_next = EXC_ILLEGAL_ADDR;
                            end else begin
                                coil_we    = 1'b1;
                                kind_next  = K_ECHO;
                                rlen_next  = 8'd5;
                                alert_next = in_crit(addr_reg, crit_low, crit_high);
                                aaddr_next = addr_reg[7:0];
                            end
                        end
                    end
                    FC_WRITE_REG: begin
                        if (job_reg.plen == 8'd5) begin
                            if (addr_reg >= 16'(REGISTER_COUNT)) begin
                                exc_next = EXC_ILLEGAL_ADDR;
                            end else begin
                                reg_we     = 1'b1;
                                kind_next  = K_ECHO;
                                rlen_next  = 8'd5;
                                alert_next = in_crit(addr_reg, crit_low, crit_high);
                                aaddr_next = addr_reg[7:0];
                            end
                        end
                    end
                    FC_WRITE_MULTI: begin
                        if (job_reg.plen >= 8'd6 && qty_reg != 16'd0
                            && qty_reg <= MAX_WRITE_REGS && bc_reg == 8'(qty_reg << 1)
                            && {1'b0, job_reg.plen} == 9'd6 + {1'b0, bc_reg}) begin
                            if (span > 17'(REGISTER_COUNT)) begin
                                exc_next = EXC_ILLEGAL_ADDR;
                            end else begin
                                kind_next  = K_ECHO;
                                rlen_next  = 8'd5;
                                state_next = ST_WMUL;
                            end
                        end
                    end
                    default: begin
                        exc_next = EXC_ILLEGAL_FUNC;
                    end
                endcase
            end
            ST_WMUL: begin
                pdu_raddr = PDU_AW'(8'd6 + {idx_reg[6:0], 1'b0} + {7'd0, phase_reg[0]});
                phase_next = phase_reg + 4'd1;
                if (phase_reg == 4'd1) begin
                    word_next[15:8] = pdu_rdata;
                end else if (phase_reg == 4'd2) begin
                    reg_we     = 1'b1;
                    reg_waddr  = a_plus_i[REG_AW-1:0];
                    reg_wdata  = {word_reg[15:8], pdu_rdata};
                    phase_next = '0;
                    if (!alert_reg && in_crit(a_plus_i, crit_low, crit_high)) begin
                        alert_next = 1'b1;
                        aaddr_next = a_plus_i[7:0];
                    end
                    if ({8'd0, idx_reg} == qty_reg - 16'd1) begin
                        state_next = ST_EMIT;
                    end else begin
                        idx_next = idx_reg + 8'd1;
                    end
                end
            end
            ST_EMIT: begin
                if (need_fetch) begin
                    phase_next = '0;
                    state_next = ST_FETCH;
                end else if (!complete || out_free) begin
                    n_next = n_reg + 9'd1;
                    if (n_reg >= 9'(HDR_LEN) && p >= 9'd2
                        && (kind_reg == K_COILS || (kind_reg == K_REGS && p[0]))) begin
                        have_next = 1'b0;
                    end
                    if (complete) begin
                        out_push     = 1'b1;
                        m_data_next  = beat_new;
                        m_bytes_next = 4'(bcnt_reg) + 4'd1;
                        m_last_next  = is_last;
                        m_drop_next  = 1'b0;
                        m_alert_next = is_last && alert_reg;
                        m_aaddr_next = (is_last && alert_reg) ? aaddr_reg : 8'd0;
                        beat_next    = '0;
                        bcnt_next    = '0;
                        if (is_last) begin
                            state_next = ST_IDLE;
                        end
                    end else begin
                        beat_next = beat_new;
                        bcnt_next = bcnt_reg + 1'b1;
                    end
                end
            end
            ST_FETCH: begin
                phase_next = phase_reg + 4'd1;
                if (kind_reg == K_REGS) begin
                    if (phase_reg == 4'd1) begin
                        word_next  = reg_word;
                        ptr_next   = ptr_reg + 1'b1;
                        have_next  = 1'b1;
                        state_next = ST_EMIT;
                    end
                end else begin
                    if (phase_reg == 4'd0) begin
                        word_next = '0;
                    end else begin
                        word_next[phase_reg[2:0] - 3'd1] = issued_reg & coil_bit;
                    end
                    if (phase_reg < 4'd8) begin
                        issued_next = (rem_reg != 16'd0);
                        if (rem_reg != 16'd0) begin
                            ptr_next = ptr_reg + 1'b1;
                            rem_next = rem_reg - 16'd1;
                        end
                    end else begin
                        have_next  = 1'b1;
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_DROP: begin
                if (out_free) begin
                    out_push     = 1'b1;
                    m_data_next  = '0;
                    m_bytes_next = '0;
                    m_last_next  = 1'b1;
                    m_drop_next  = 1'b1;
                    m_alert_next = 1'b0;
                    m_aaddr_next = '0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_push) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_valid_reg  <= 1'b0;
            beat_reg     <= '0;
            bcnt_reg     <= '0;
            coil_vld_reg <= '0;
            rvld_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            beat_reg    <= beat_next;
            bcnt_reg    <= bcnt_next;
            if (coil_we) begin
                coil_vld_reg[coil_waddr] <= 1'b1;
            end
            if (reg_we) begin
                rvld_reg[reg_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg    <= kind_next;
        job_reg     <= job_next;
        fc_reg      <= fc_next;
        bc_reg      <= bc_next;
        exc_reg     <= exc_next;
        addr_reg    <= addr_next;
        qty_reg     <= qty_next;
        rlen_reg    <= rlen_next;
        idx_reg     <= idx_next;
        phase_reg   <= phase_next;
        n_reg       <= n_next;
        ptr_reg     <= ptr_next;
        rem_reg     <= rem_next;
        word_reg    <= word_next;
        have_reg    <= have_next;
        issued_reg  <= issued_next;
        alert_reg   <= alert_next;
        aaddr_reg   <= aaddr_next;
        coil_vq_reg <= coil_vld_reg[coil_raddr];
        rvq_reg     <= rvld_reg[reg_raddr];
        m_data_reg  <= m_data_next;
        m_bytes_reg <= m_bytes_next;
        m_last_reg  <= m_last_next;
        m_drop_reg  <= m_drop_next;
        m_alert_reg <= m_alert_next;
        m_aaddr_reg <= m_aaddr_next;
    end

endmodule

// ===== hw/rtl/mbtcp_checker.sv =====
// port-level checks on the response channel of the server engine
// bound to modbus_tcp_server_engine_unit
module mbtcp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [63:0] m_beat_data,
    input logic [3:0]  m_beat_bytes,
    input logic        m_last_beat,
    input logic        m_drop,
    input logic        m_alert
);

    a_drop_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_drop |-> m_beat_bytes == 4'd0 && m_last_beat && !m_alert)
        else $error("drop beat malformed");

    a_alert_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_alert |-> m_last_beat && !m_drop)
        else $error("alert off the final beat");

    a_mid_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last_beat |-> m_beat_bytes == 4'd8 && !m_drop)
        else $error("short beat before end of response");

    a_resp_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_drop |-> m_beat_bytes != 4'd0 && m_beat_bytes <= 4'd8)
        else $error("bad byte count");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_beat_data))
        else $error("stalled beat changed");

endmodule

bind modbus_tcp_server_engine_unit mbtcp_checker u_mbtcp_checker (
    .aclk(aclk), .aresetn(aresetn), .m_valid(m_valid), .m_ready(m_ready),
    .m_beat_data(m_beat_data), .m_beat_bytes(m_beat_bytes),
    .m_last_beat(m_last_beat), .m_drop(m_drop), .m_alert(m_alert)
);
